// File: hw/rtl/cbpm_pkg.sv
// Shared codes and types for the clock buffer pool manager.
package cbpm_pkg;

  // Request kinds
  localparam logic [2:0] KIND_READ    = 3'd0;
  localparam logic [2:0] KIND_UNPIN   = 3'd1;
  localparam logic [2:0] KIND_ALLOC   = 3'd2;
  localparam logic [2:0] KIND_DISPOSE = 3'd3;
  localparam logic [2:0] KIND_FLUSH   = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FREE  = 3'd1;
  localparam logic [2:0] ST_NOT_RES  = 3'd2;
  localparam logic [2:0] ST_NOT_PIN  = 3'd3;
  localparam logic [2:0] ST_PINNED   = 3'd4;
  localparam logic [2:0] ST_RESIDENT = 3'd5;

  // Frame cell operations
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_CLEAR  = 3'd1;
  localparam logic [2:0] OP_SETUP  = 3'd2;
  localparam logic [2:0] OP_HIT    = 3'd3;
  localparam logic [2:0] OP_UNPIN  = 3'd4;
  localparam logic [2:0] OP_CLRREF = 3'd5;

  localparam logic [15:0] PIN_MAX = 16'hFFFF;

  // Command broadcast to every cell
  typedef struct packed {
    logic [2:0]  op;
    logic        set_dirty;
    logic [7:0]  file;
    logic [23:0] page;
  } cell_cmd_t;

  // State a cell shows to the sequencer
  typedef struct packed {
    logic        valid;
    logic        dirty;
    logic        refb;
    logic        pins_nz;
    logic [7:0]  file;
    logic [23:0] page;
  } cell_stat_t;

endpackage

// File: hw/rtl/clock_buffer_pool_manager.sv
// Top level: request sequencer over a row of buffer frame cells.
// Buffer pool frame manager with clock replacement. Issue an item with start
// while busy is low; results come one per cycle on the out_ ports, each marked
// by out_valid for one cycle, and cannot be held off. The last result of an
// item has out_last set; a write-back result (out_action 1) precedes the final
// result of a read miss or allocate that evicts a dirty frame, and of each
// dirty frame a flush drops. The clock hand and the flush walk visit one frame
// per cycle: a read miss or allocate sweeps 1 to 2*NUM_FRAMES frames from the
// hand, a flush walks all frames in order but stops early on a pinned frame of
// its file, and a read hit, unpin, dispose or unknown kind needs neither.
// busy drops in the cycle the final result appears.
module clock_buffer_pool_manager #(
  parameter int NUM_FRAMES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_file_id,
  input  logic [23:0] in_page_no,
  input  logic        in_set_dirty,
  output logic        out_valid,
  output logic        out_action,
  output logic [7:0]  out_file,
  output logic [23:0] out_page,
  output logic [4:0]  out_frame,
  output logic        out_need_fetch,
  output logic [2:0]  out_status,
  output logic        out_last
);

  localparam int IW = $clog2(NUM_FRAMES);
  localparam int CW = $clog2(2 * NUM_FRAMES);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_FRAMES - 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(2 * NUM_FRAMES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_FEND  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  kind_r;
  logic [7:0]  file_r;
  logic [23:0] page_r;
  logic        sd_r;
  logic [IW-1:0] hand_r, hand_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  logic        ov_r, oact_r, onf_r, olast_r;
  logic [7:0]  ofile_r;
  logic [23:0] opage_r;
  logic [4:0]  oframe_r;
  logic [2:0]  ost_r;

  logic          emit, e_act, e_nf, e_last;
  logic [7:0]    e_file;
  logic [23:0]   e_page;
  logic [IW-1:0] e_frame;
  logic [2:0]    e_st;
  logic [IW+4:0] e_frame_ext;

  cbpm_pkg::cell_cmd_t  cmd;
  logic [2:0]           cmd_op;
  logic [IW-1:0]        tgt;
  cbpm_pkg::cell_stat_t stat [NUM_FRAMES];
  cbpm_pkg::cell_stat_t sel_stat;
  logic [IW-1:0]        sel_idx;
  logic [IW-1:0]        hand_step;
  logic                 found [NUM_FRAMES+1];
  logic [IW-1:0]        cidx  [NUM_FRAMES+1];
  logic                 hit;
  logic [IW-1:0]        hidx;
  logic                 own;

  assign cmd.op        = cmd_op;
  assign cmd.set_dirty = sd_r;
  assign cmd.file      = file_r;
  assign cmd.page      = page_r;

  // Row of frame cells linked by the lookup chain
  assign found[0] = 1'b0;
  assign cidx[0]  = '0;
  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    cbpm_cell #(.IW(IW), .MY_IDX(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .tgt       (tgt),
      .found_in  (found[g]),
      .idx_in    (cidx[g]),
      .found_out (found[g+1]),
      .idx_out   (cidx[g+1]),
      .stat      (stat[g])
    );
  end
  assign hit  = found[NUM_FRAMES];
  assign hidx = cidx[NUM_FRAMES];

  assign hand_step = (hand_r == LAST_IDX) ? '0 : hand_r + IW'(1);
  assign sel_stat  = stat[sel_idx];
  assign own       = sel_stat.valid && (sel_stat.file == file_r);
  assign busy      = (state_r != S_IDLE);

  // Sequence the request over the cells
  always_comb begin
    state_nxt = state_r;
    hand_nxt  = hand_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    sel_idx   = idx_r;
    cmd_op    = cbpm_pkg::OP_NONE;
    tgt       = idx_r;
    emit      = 1'b0;
    e_act     = 1'b0;
    e_file    = 8'd0;
    e_page    = 24'd0;
    e_frame   = '0;
    e_nf      = 1'b0;
    e_st      = cbpm_pkg::ST_OK;
    e_last    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cnt_nxt = '0;
          idx_nxt = '0;
          if (in_kind == cbpm_pkg::KIND_ALLOC)      state_nxt = S_SWEEP;
          else if (in_kind == cbpm_pkg::KIND_FLUSH) state_nxt = S_FLUSH;
          else                                      state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        sel_idx   = hidx;
        tgt       = hidx;
        emit      = 1'b1;
        e_last    = 1'b1;
        state_nxt = S_IDLE;
        case (kind_r)
          cbpm_pkg::KIND_READ: begin
            if (hit) begin
              cmd_op  = cbpm_pkg::OP_HIT;
              e_frame = hidx;
            end else begin
              emit      = 1'b0;
              e_last    = 1'b0;
              state_nxt = S_SWEEP;
            end
          end
          cbpm_pkg::KIND_UNPIN: begin
            if (!hit) begin
              e_st = cbpm_pkg::ST_NOT_RES;
            end else if (!sel_stat.pins_nz) begin
              e_st    = cbpm_pkg::ST_NOT_PIN;
              e_frame = hidx;
            end else begin
              cmd_op  = cbpm_pkg::OP_UNPIN;
              e_frame = hidx;
            end
          end
          cbpm_pkg::KIND_DISPOSE: begin
            if (hit) begin
              cmd_op  = cbpm_pkg::OP_CLEAR;
              e_frame = hidx;
            end
          end
          default: ;
        endcase
      end
      S_SWEEP: begin
        sel_idx  = hand_step;
        tgt      = hand_step;
        hand_nxt = hand_step;
        cnt_nxt  = cnt_r + CW'(1);
        if (!sel_stat.valid) begin
          cmd_op    = cbpm_pkg::OP_CLEAR;
          idx_nxt   = hand_step;
          state_nxt = S_FIN;
        end else if (sel_stat.pins_nz) begin
          cmd_op = cbpm_pkg::OP_NONE;
        end else if (sel_stat.refb) begin
          cmd_op = cbpm_pkg::OP_CLRREF;
        end else begin
          // evict, writing back a dirty page first
          emit      = sel_stat.dirty;
          e_act     = 1'b1;
          e_file    = sel_stat.file;
          e_page    = sel_stat.page;
          e_frame   = hand_step;
          cmd_op    = cbpm_pkg::OP_CLEAR;
          idx_nxt   = hand_step;
          state_nxt = S_FIN;
        end
        if (state_nxt == S_SWEEP && cnt_r == LAST_CNT) begin
          emit      = 1'b1;
          e_st      = cbpm_pkg::ST_NO_FREE;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        emit      = 1'b1;
        e_last    = 1'b1;
        e_frame   = idx_r;
        state_nxt = S_IDLE;
        if (kind_r == cbpm_pkg::KIND_READ) begin
          cmd_op = cbpm_pkg::OP_SETUP;
          e_nf   = 1'b1;
        end else if (hit) begin
          e_st = cbpm_pkg::ST_RESIDENT;
        end else begin
          cmd_op = cbpm_pkg::OP_SETUP;
        end
      end
      S_FLUSH: begin
        if (own && sel_stat.pins_nz) begin
          emit      = 1'b1;
          e_st      = cbpm_pkg::ST_PINNED;
          e_frame   = idx_r;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          if (own) begin
            cmd_op  = cbpm_pkg::OP_CLEAR;
            emit    = sel_stat.dirty;
            e_act   = 1'b1;
            e_file  = sel_stat.file;
            e_page  = sel_stat.page;
            e_frame = idx_r;
          end
          if (idx_r == LAST_IDX) state_nxt = S_FEND;
          else                   idx_nxt   = idx_r + IW'(1);
        end
      end
      S_FEND: begin
        emit      = 1'b1;
        e_last    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign e_frame_ext = {5'd0, e_frame};

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hand_r  <= LAST_IDX;
      cnt_r   <= '0;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hand_r  <= hand_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= emit;
    end
  end

  // Hold the request and the result payload
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_r <= in_kind;
      file_r <= in_file_id;
      page_r <= in_page_no;
      sd_r   <= in_set_dirty;
    end
    oact_r   <= e_act;
    ofile_r  <= e_file;
    opage_r  <= e_page;
    oframe_r <= e_frame_ext[4:0];
    onf_r    <= e_nf;
    ost_r    <= e_st;
    olast_r  <= e_last;
  end

  assign out_valid      = ov_r;
  assign out_action     = oact_r;
  assign out_file       = ofile_r;
  assign out_page       = opage_r;
  assign out_frame      = oframe_r;
  assign out_need_fetch = onf_r;
  assign out_status     = ost_r;
  assign out_last       = olast_r;

`ifndef ASSERT_OFF
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy) else $error("busy after final item");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item not in progress");
  a_wb_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action) |-> !out_last) else $error("write-back marked last");
  a_fetch_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_need_fetch) |-> (out_last && out_status == cbpm_pkg::ST_OK))
    else $error("fetch on non-final result");
`endif

endmodule

// File: hw/rtl/cbpm_cell.sv
// One buffer frame cell with its link in the lookup priority chain.
module cbpm_cell #(
  parameter int IW     = 5,
  parameter int MY_IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cbpm_pkg::cell_cmd_t   cmd,
  input  logic [IW-1:0]         tgt,
  input  logic                  found_in,
  input  logic [IW-1:0]         idx_in,
  output logic                  found_out,
  output logic [IW-1:0]         idx_out,
  output cbpm_pkg::cell_stat_t  stat
);

  logic        valid_r, valid_nxt;
  logic        dirty_r, dirty_nxt;
  logic        ref_r, ref_nxt;
  logic [15:0] pins_r, pins_nxt;
  logic [7:0]  file_r;
  logic [23:0] page_r;
  logic        sel;
  logic        match;

  assign sel = (tgt == IW'(MY_IDX));

  // Match the request tag and pass the first hit down the chain
  assign match     = valid_r && (file_r == cmd.file) && (page_r == cmd.page);
  assign found_out = found_in | match;
  assign idx_out   = found_in ? idx_in : (match ? IW'(MY_IDX) : idx_in);

  // Decode the operation for this frame
  always_comb begin
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    ref_nxt   = ref_r;
    pins_nxt  = pins_r;
    if (sel) begin
      case (cmd.op)
        cbpm_pkg::OP_CLEAR: begin
          valid_nxt = 1'b0;
          dirty_nxt = 1'b0;
          ref_nxt   = 1'b0;
          pins_nxt  = 16'd0;
        end
        cbpm_pkg::OP_SETUP: begin
          valid_nxt = 1'b1;
          dirty_nxt = 1'b0;
          ref_nxt   = 1'b1;
          pins_nxt  = 16'd1;
        end
        cbpm_pkg::OP_HIT: begin
          ref_nxt = 1'b1;
          if (pins_r != cbpm_pkg::PIN_MAX) pins_nxt = pins_r + 16'd1;
        end
        cbpm_pkg::OP_UNPIN: begin
          pins_nxt  = pins_r - 16'd1;
          dirty_nxt = dirty_r | cmd.set_dirty;
        end
        cbpm_pkg::OP_CLRREF: ref_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      ref_r   <= 1'b0;
      pins_r  <= 16'd0;
    end else begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      ref_r   <= ref_nxt;
      pins_r  <= pins_nxt;
    end
  end

  // Load the tag on setup
  always_ff @(posedge clk) begin
    if (sel && cmd.op == cbpm_pkg::OP_SETUP) begin
      file_r <= cmd.file;
      page_r <= cmd.page;
    end
  end

  assign stat.valid   = valid_r;
  assign stat.dirty   = dirty_r;
  assign stat.refb    = ref_r;
  assign stat.pins_nz = (pins_r != 16'd0);
  assign stat.file    = file_r;
  assign stat.page    = page_r;

endmodule

// File: tb/clock_buffer_pool_manager_tb.sv
// Self-checking testbench for the clock buffer pool manager.
`timescale 1ns / 1ps

module clock_buffer_pool_manager_tb;

  localparam int NFR = 32;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 186;
  localparam logic [2:0] KIND_BAD_LO = 3'd5;
  localparam logic [2:0] KIND_BAD_MID = 3'd6;
  localparam logic [2:0] KIND_BAD_HI = 3'd7;

  typedef struct {
    logic        action;
    logic [7:0]  file;
    logic [23:0] page;
    logic [4:0]  frame;
    logic        need_fetch;
    logic [2:0]  status;
    logic        last;
  } pool_result_t;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  file;
    logic [23:0] page;
    logic        sd;
    bit          typed;
    logic [4:0]  frame;
    logic        nf;
    logic [2:0]  status;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_kind = '0;
  logic [7:0]  in_file_id = '0;
  logic [23:0] in_page_no = '0;
  logic        in_set_dirty = 1'b0;
  logic        out_valid, out_action, out_need_fetch, out_last;
  logic [7:0]  out_file;
  logic [23:0] out_page;
  logic [4:0]  out_frame;
  logic [2:0]  out_status;

  // Predictor copy of the frame table
  bit          frame_valid [NFR];
  bit          frame_dirty [NFR];
  bit          frame_ref   [NFR];
  logic [15:0] frame_pins  [NFR];
  logic [7:0]  frame_file  [NFR];
  logic [23:0] frame_page  [NFR];
  int          hand;

  pool_result_t expected_q[$];
  pool_result_t step_q[$];
  int   errors = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   writebacks_seen = 0;
  int   cycles = 0;
  bit   cur_typed = 1'b0;
  pool_result_t cur_typed_res;
  dir_row_t dir_rows[$];

  clock_buffer_pool_manager #(.NUM_FRAMES(NFR)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_file_id(in_file_id), .in_page_no(in_page_no),
    .in_set_dirty(in_set_dirty), .out_valid(out_valid), .out_action(out_action),
    .out_file(out_file), .out_page(out_page), .out_frame(out_frame),
    .out_need_fetch(out_need_fetch), .out_status(out_status), .out_last(out_last)
  );

  always #5 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
      $display("clock_buffer_pool_manager_tb: done, errors");
      $finish;
    end
  end

  task automatic emit_result(logic a, logic [7:0] f, logic [23:0] p, int fr,
                             logic nf, logic [2:0] st, logic l);
    pool_result_t r;
    r.action = a; r.file = f; r.page = p; r.frame = fr[4:0];
    r.need_fetch = nf; r.status = st; r.last = l;
    step_q.push_back(r);
  endtask

  function automatic void clear_frame(int i);
    frame_valid[i] = 1'b0; frame_dirty[i] = 1'b0; frame_ref[i] = 1'b0;
    frame_pins[i] = '0;
  endfunction

  function automatic void setup_frame(int i, logic [7:0] f, logic [23:0] p);
    frame_valid[i] = 1'b1; frame_dirty[i] = 1'b0; frame_ref[i] = 1'b1;
    frame_pins[i] = 16'd1; frame_file[i] = f; frame_page[i] = p;
  endfunction

  function automatic int lookup_frame(logic [7:0] f, logic [23:0] p);
    for (int i = 0; i < NFR; i++)
      if (frame_valid[i] && frame_file[i] == f && frame_page[i] == p) return i;
    return -1;
  endfunction

  // Sweep the clock hand for a victim; may queue a write-back
  task automatic sweep_victim(output int taken);
    taken = -1;
    for (int c = 0; c < 2 * NFR; c++) begin
      hand = (hand + 1 >= NFR) ? 0 : hand + 1;
      if (!frame_valid[hand]) begin
        clear_frame(hand);
        taken = hand;
        return;
      end
      if (frame_pins[hand] != 16'd0) continue;
      if (frame_ref[hand]) begin
        frame_ref[hand] = 1'b0;
        continue;
      end
      if (frame_dirty[hand])
        emit_result(1'b1, frame_file[hand], frame_page[hand], hand, 1'b0,
                    cbpm_pkg::ST_OK, 1'b0);
      clear_frame(hand);
      taken = hand;
      return;
    end
  endtask

  // Work out the results of one request into step_q
  task automatic predict_request(logic [2:0] kind, logic [7:0] f, logic [23:0] p,
                                 logic sd);
    int fr;
    bit stopped;
    step_q.delete();
    case (kind)
      cbpm_pkg::KIND_READ: begin
        fr = lookup_frame(f, p);
        if (fr >= 0) begin
          frame_ref[fr] = 1'b1;
          if (frame_pins[fr] < cbpm_pkg::PIN_MAX) frame_pins[fr]++;
          emit_result(1'b0, '0, '0, fr, 1'b0, cbpm_pkg::ST_OK, 1'b1);
        end else begin
          sweep_victim(fr);
          if (fr < 0) emit_result(1'b0, '0, '0, 0, 1'b0, cbpm_pkg::ST_NO_FREE, 1'b1);
          else begin
            setup_frame(fr, f, p);
            emit_result(1'b0, '0, '0, fr, 1'b1, cbpm_pkg::ST_OK, 1'b1);
          end
        end
      end
      cbpm_pkg::KIND_UNPIN: begin
        fr = lookup_frame(f, p);
        if (fr < 0) emit_result(1'b0, '0, '0, 0, 1'b0, cbpm_pkg::ST_NOT_RES, 1'b1);
        else if (frame_pins[fr] == 16'd0)
          emit_result(1'b0, '0, '0, fr, 1'b0, cbpm_pkg::ST_NOT_PIN, 1'b1);
        else begin
          frame_pins[fr]--;
          if (sd) frame_dirty[fr] = 1'b1;
          emit_result(1'b0, '0, '0, fr, 1'b0, cbpm_pkg::ST_OK, 1'b1);
        end
      end
      cbpm_pkg::KIND_ALLOC: begin
        sweep_victim(fr);
        if (fr < 0) emit_result(1'b0, '0, '0, 0, 1'b0, cbpm_pkg::ST_NO_FREE, 1'b1);
        else if (lookup_frame(f, p) >= 0)
          emit_result(1'b0, '0, '0, fr, 1'b0, cbpm_pkg::ST_RESIDENT, 1'b1);
        else begin
          setup_frame(fr, f, p);
          emit_result(1'b0, '0, '0, fr, 1'b0, cbpm_pkg::ST_OK, 1'b1);
        end
      end
      cbpm_pkg::KIND_DISPOSE: begin
        fr = lookup_frame(f, p);
        if (fr >= 0) clear_frame(fr);
        emit_result(1'b0, '0, '0, (fr >= 0) ? fr : 0, 1'b0, cbpm_pkg::ST_OK, 1'b1);
      end
      cbpm_pkg::KIND_FLUSH: begin
        stopped = 1'b0;
        for (int i = 0; i < NFR && !stopped; i++) begin
          if (frame_valid[i] && frame_file[i] == f) begin
            if (frame_pins[i] != 16'd0) begin
              emit_result(1'b0, '0, '0, i, 1'b0, cbpm_pkg::ST_PINNED, 1'b1);
              stopped = 1'b1;
            end else begin
              if (frame_dirty[i])
                emit_result(1'b1, frame_file[i], frame_page[i], i, 1'b0,
                            cbpm_pkg::ST_OK, 1'b0);
              clear_frame(i);
            end
          end
        end
        if (!stopped) emit_result(1'b0, '0, '0, 0, 1'b0, cbpm_pkg::ST_OK, 1'b1);
      end
      default: emit_result(1'b0, '0, '0, 0, 1'b0, cbpm_pkg::ST_OK, 1'b1);
    endcase
  endtask

  // Check results and predict accepted items at each rising edge
  always @(posedge clk) begin
    pool_result_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_action) writebacks_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result frame=%0d status=%0d", $time, out_frame, out_status);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (e.action !== out_action || e.file !== out_file || e.page !== out_page ||
            e.frame !== out_frame || e.need_fetch !== out_need_fetch ||
            e.status !== out_status || e.last !== out_last) begin
          $display("%0t: mismatch expected act=%0d file=%0d page=%0d frame=%0d nf=%0d st=%0d last=%0d",
                   $time, e.action, e.file, e.page, e.frame, e.need_fetch, e.status, e.last);
          $display("%0t:          actual   act=%0d file=%0d page=%0d frame=%0d nf=%0d st=%0d last=%0d",
                   $time, out_action, out_file, out_page, out_frame, out_need_fetch,
                   out_status, out_last);
          errors++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      items_sent++;
      predict_request(in_kind, in_file_id, in_page_no, in_set_dirty);
      if (cur_typed) expected_q.push_back(cur_typed_res);
      else foreach (step_q[k]) expected_q.push_back(step_q[k]);
    end
  end

  // Present one item from the falling edge and hold it until accepted
  task automatic send_item(logic [2:0] kind, logic [7:0] f, logic [23:0] p, logic sd);
    @(negedge clk);
    start <= 1'b1;
    in_kind <= kind; in_file_id <= f; in_page_no <= p; in_set_dirty <= sd;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Drop start for a random number of cycles
  task automatic sender_gap(int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain_pool();
    @(negedge clk);
    start <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (4 * NFR) @(posedge clk);
  endtask

  task automatic add_row(logic [2:0] kind, logic [7:0] f, logic [23:0] p, logic sd,
                         bit typed, int fr, logic nf, logic [2:0] st);
    dir_row_t r;
    r.kind = kind; r.file = f; r.page = p; r.sd = sd; r.typed = typed;
    r.frame = fr[4:0]; r.nf = nf; r.status = st;
    dir_rows.push_back(r);
  endtask

  task automatic random_item(int pct);
    int sel;
    logic [2:0] kind;
    logic [7:0] f;
    logic [23:0] p;
    sel = $urandom_range(99);
    kind = (sel < 40) ? cbpm_pkg::KIND_READ : (sel < 70) ? cbpm_pkg::KIND_UNPIN :
           (sel < 80) ? cbpm_pkg::KIND_ALLOC : (sel < 90) ? cbpm_pkg::KIND_DISPOSE :
           (sel < 96) ? cbpm_pkg::KIND_FLUSH : 3'($urandom_range(5, 7));
    // keep most traffic on a small page set so hits, pins and evictions occur
    f = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    p = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(23));
    sender_gap(pct);
    send_item(kind, f, p, 1'($urandom));
  endtask

  initial begin
    pool_result_t t;
    for (int i = 0; i < NFR; i++) begin
      clear_frame(i);
      frame_file[i] = '0;
      frame_page[i] = '0;
    end
    hand = NFR - 1;

    // Directed rows: extremes, every kind, hits, status codes
    add_row(cbpm_pkg::KIND_READ, 8'd1, 24'd0, 1'b0, 1'b1, 0, 1'b1, cbpm_pkg::ST_OK);
    add_row(cbpm_pkg::KIND_READ, 8'hFF, 24'hFFFFFF, 1'b0, 1'b1, 1, 1'b1, cbpm_pkg::ST_OK);
    add_row(cbpm_pkg::KIND_READ, 8'd1, 24'd0, 1'b0, 1'b1, 0, 1'b0, cbpm_pkg::ST_OK);
    add_row(cbpm_pkg::KIND_UNPIN, 8'd1, 24'd0, 1'b1, 1'b1, 0, 1'b0, cbpm_pkg::ST_OK);
    add_row(cbpm_pkg::KIND_UNPIN, 8'd1, 24'd0, 1'b0, 1'b0, 0, 1'b0, cbpm_pkg::ST_OK);
    add_row(cbpm_pkg::KIND_UNPIN, 8'd1, 24'd0, 1'b0, 1'b1, 0, 1'b0, cbpm_pkg::ST_NOT_PIN);
    add_row(cbpm_pkg::KIND_UNPIN, 8'd9, 24'd5, 1'b1, 1'b1, 0, 1'b0, cbpm_pkg::ST_NOT_RES);
    add_row(cbpm_pkg::KIND_ALLOC, 8'd1, 24'd0, 1'b0, 1'b1, 2, 1'b0, cbpm_pkg::ST_RESIDENT);
    add_row(cbpm_pkg::KIND_ALLOC, 8'd2, 24'd7, 1'b0, 1'b1, 3, 1'b0, cbpm_pkg::ST_OK);
    add_row(cbpm_pkg::KIND_DISPOSE, 8'd2, 24'd7, 1'b0, 1'b1, 3, 1'b0, cbpm_pkg::ST_OK);
    add_row(cbpm_pkg::KIND_DISPOSE, 8'd3, 24'd3, 1'b0, 1'b1, 0, 1'b0, cbpm_pkg::ST_OK);
    add_row(cbpm_pkg::KIND_FLUSH, 8'hFF, 24'd0, 1'b0, 1'b1, 1, 1'b0, cbpm_pkg::ST_PINNED);
    add_row(cbpm_pkg::KIND_UNPIN, 8'hFF, 24'hFFFFFF, 1'b1, 1'b0, 0, 1'b0, cbpm_pkg::ST_OK);
    add_row(cbpm_pkg::KIND_FLUSH, 8'hFF, 24'hFFFFFF, 1'b0, 1'b0, 0, 1'b0, cbpm_pkg::ST_OK);
    add_row(cbpm_pkg::KIND_FLUSH, 8'd1, 24'd0, 1'b1, 1'b0, 0, 1'b0, cbpm_pkg::ST_OK);
    add_row(cbpm_pkg::KIND_READ, 8'hAA, 24'h555555, 1'b0, 1'b0, 0, 1'b0, cbpm_pkg::ST_OK);
    add_row(cbpm_pkg::KIND_READ, 8'h55, 24'hAAAAAA, 1'b0, 1'b0, 0, 1'b0, cbpm_pkg::ST_OK);
    add_row(KIND_BAD_LO, 8'hFF, 24'hFFFFFF, 1'b1, 1'b1, 0, 1'b0, cbpm_pkg::ST_OK);
    add_row(KIND_BAD_MID, 8'd0, 24'd0, 1'b0, 1'b1, 0, 1'b0, cbpm_pkg::ST_OK);
    add_row(KIND_BAD_HI, 8'h80, 24'h800000, 1'b1, 1'b1, 0, 1'b0, cbpm_pkg::ST_OK);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (dir_rows[r]) begin
      @(negedge clk);
      cur_typed = dir_rows[r].typed;
      t.action = 1'b0; t.file = '0; t.page = '0; t.frame = dir_rows[r].frame;
      t.need_fetch = dir_rows[r].nf; t.status = dir_rows[r].status; t.last = 1'b1;
      cur_typed_res = t;
      start <= 1'b1;
      in_kind <= dir_rows[r].kind; in_file_id <= dir_rows[r].file;
      in_page_no <= dir_rows[r].page; in_set_dirty <= dir_rows[r].sd;
      while (busy) @(negedge clk);
      @(posedge clk);
    end
    @(negedge clk);
    cur_typed = 1'b0;
    start <= 1'b0;
    drain_pool();

    // Pin every frame, then a miss and an allocate find no victim
    for (int i = 0; i < NFR; i++) send_item(cbpm_pkg::KIND_READ, 8'd7, 24'(i), 1'b0);
    send_item(cbpm_pkg::KIND_READ, 8'd7, 24'd999, 1'b0);
    send_item(cbpm_pkg::KIND_ALLOC, 8'd7, 24'd998, 1'b0);
    send_item(cbpm_pkg::KIND_FLUSH, 8'd7, 24'd0, 1'b0);
    for (int i = 0; i < NFR; i++)
      send_item(cbpm_pkg::KIND_UNPIN, 8'd7, 24'(i), 1'($urandom));
    send_item(cbpm_pkg::KIND_FLUSH, 8'd7, 24'd0, 1'b0);

    // Pin one page several times, unpin it once, then dispose of it
    for (int i = 0; i < 4; i++) send_item(cbpm_pkg::KIND_READ, 8'd8, 24'd1, 1'b0);
    send_item(cbpm_pkg::KIND_UNPIN, 8'd8, 24'd1, 1'b1);
    send_item(cbpm_pkg::KIND_DISPOSE, 8'd8, 24'd1, 1'b0);
    drain_pool();

    // Random traffic in three phases, two of them idling, drained between phases
    for (int i = 0; i < RANDOM_ITEMS / 3; i++) random_item(33);
    drain_pool();
    for (int i = 0; i < RANDOM_ITEMS / 3; i++) random_item(66);
    drain_pool();
    for (int i = 0; i < RANDOM_ITEMS / 3; i++) random_item(0);
    drain_pool();

    $display("Covered %0d items of every kind with %0d results (%0d write-backs),",
             items_sent, results_seen, writebacks_seen);
    $display("including pool exhaustion, repeated pins and flush stops on pinned frames.");
    if (errors == 0) begin
      $display("clock_buffer_pool_manager_tb: done, clean");
    end else begin
      $display("clock_buffer_pool_manager_tb: done, errors");
    end
    $finish;
  end

endmodule
